// ===== rtl/tsp_pkg.sv =====
// Package for the telemetry sentence parser: request/response payload types,
// character constants, status codes and the classified-byte record.
// No dependencies.
package tsp_pkg;

   // Character constants
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UPA   = 8'h41;
   localparam logic [7:0] CH_UPF   = 8'h46;
   localparam logic [7:0] CH_LOA   = 8'h61;
   localparam logic [7:0] CH_LOF   = 8'h66;

   // Sentence identifier "MB1", first letter at index 0
   localparam int unsigned ID_LEN = 3;
   localparam logic [ID_LEN-1:0][7:0] ID_TEXT = {8'h31, 8'h42, 8'h4D};

   // Number of decimal readings in a sentence
   localparam int unsigned NUM_READINGS = 6;
   localparam logic [2:0]  LAST_FIELD   = 3'd6;
   localparam logic [1:0]  ID_DONE      = 2'd3;

   // Status codes, lowest nonzero code wins
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NO_STAR     = 3'd1;
   localparam logic [2:0] ST_BAD_HEX     = 3'd2;
   localparam logic [2:0] ST_MISMATCH    = 3'd3;
   localparam logic [2:0] ST_TOO_MANY    = 3'd4;
   localparam logic [2:0] ST_FIELD_COUNT = 3'd5;
   localparam logic [2:0] ST_BAD_ID      = 3'd6;
   localparam logic [2:0] ST_BAD_NUMBER  = 3'd7;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] reading_1;
      logic [31:0] reading_2;
      logic [31:0] reading_3;
      logic [31:0] reading_4;
      logic [31:0] reading_5;
      logic [31:0] reading_6;
   } rsp_type;

   // One byte after classification by the front end
   typedef struct packed {
      logic [7:0]        data;
      logic              last;
      logic              is_star;
      logic              is_comma;
      logic              is_digit;
      logic [3:0]        digit;
      logic              is_hex;
      logic [3:0]        hex;
      logic [ID_LEN-1:0] id_hit;
   } class_type;

endpackage

// ===== rtl/telemetry_sentence_parser.sv =====
// Telemetry sentence parser. Accepts one byte of an "MB1,n1,...,n6*HH"
// sentence per cycle and returns one status plus six readings when the byte
// flagged end_of_packet has been taken; other bytes produce no result. A
// request is written into a classification queue at the edge that accepts
// it, the parser consumes one queued byte per clock, and when no earlier
// byte is still queued the result of a closing byte is written into the
// response queue at the edge where the parser takes it, and shows from then on.
// Sustained rate is one byte per cycle, set by the single parser
// stage; it slows only when the response queue is full and a closing byte
// waits for room. Depths of both queues are set by REQ_DEPTH and RSP_DEPTH.
// Depends on tsp_pkg, tsp_front, tsp_fifo, tsp_back.
module telemetry_sentence_parser import tsp_pkg::*; #(
   parameter int unsigned REQ_DEPTH = 2,
   parameter int unsigned RSP_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   class_type cls;
   class_type item;
   logic      item_empty;
   logic      item_pop;
   logic      back_rsp_push;
   logic      back_rsp_full;
   rsp_type   back_rsp_data;

   tsp_front u_front (
      .req (req_data),
      .cls (cls)
   );

   tsp_fifo #(
      .WIDTH ($bits(class_type)),
      .DEPTH (REQ_DEPTH)
   ) u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cls),
      .full      (full),
      .pop       (item_pop),
      .pop_data  (item),
      .empty     (item_empty)
   );

   tsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (!item_empty),
      .item_pop   (item_pop),
      .rsp_full   (back_rsp_full),
      .rsp_push   (back_rsp_push),
      .rsp_data   (back_rsp_data)
   );

   tsp_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_rsp_push),
      .push_data (back_rsp_data),
      .full      (back_rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

endmodule

// ===== rtl/tsp_fifo.sv =====
// Small synchronous queue with push/full and pop/empty sides.
// Generic width; no package dependency.
module tsp_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/tsp_front.sv =====
// Front end of the sentence parser: classifies each incoming byte.
// Depends on tsp_pkg.
module tsp_front import tsp_pkg::*; (
   input  req_type   req,
   output class_type cls
);

   // Classify the byte: separators, decimal digit, hex digit, id letters
   always_comb begin
      logic [7:0] c;
      c = req.byte_in;
      cls          = '0;
      cls.data     = c;
      cls.last     = req.end_of_packet;
      cls.is_star  = (c == CH_STAR);
      cls.is_comma = (c == CH_COMMA);
      cls.is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      cls.digit    = c[3:0];
      if (cls.is_digit) begin
         cls.is_hex = 1'b1;
         cls.hex    = c[3:0];
      end else if ((c >= CH_UPA && c <= CH_UPF) || (c >= CH_LOA && c <= CH_LOF)) begin
         cls.is_hex = 1'b1;
         cls.hex    = c[3:0] + 4'd9;
      end
      for (int i = 0; i < ID_LEN; i++) begin
         cls.id_hit[i] = (c == ID_TEXT[i]);
      end
   end

endmodule

// ===== rtl/tsp_back.sv =====
// Back end of the sentence parser: field, identifier, decimal and checksum
// state, and the final status on the closing byte. Depends on tsp_pkg.
module tsp_back import tsp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  class_type item,
   input  logic      item_valid,
   output logic      item_pop,
   input  logic      rsp_full,
   output logic      rsp_push,
   output rsp_type   rsp_data
);

   logic        cks_ff, cks_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  hex_acc_ff, hex_acc_in;
   logic        hex_seen_ff, hex_seen_in;
   logic        hex_bad_ff, hex_bad_in;
   logic [2:0]  field_num_ff, field_num_in;
   logic        too_many_ff, too_many_in;
   logic [1:0]  id_cnt_ff, id_cnt_in;
   logic        id_bad_ff, id_bad_in;
   logic [31:0] acc_ff, acc_in;
   logic        seen_ff, seen_in;
   logic        num_bad_ff, num_bad_in;
   logic [31:0] values_ff [NUM_READINGS];
   logic [31:0] values_in [NUM_READINGS];
   logic        fire;

   // Take an item unless it closes a packet and the result queue is full
   assign fire     = item_valid && (!item.last || !rsp_full);
   assign item_pop = fire;
   assign rsp_push = fire && item.last;

   always_comb begin
      logic        close;
      logic        id_ok_char;
      logic [35:0] wide;
      logic [2:0]  st;

      cks_in       = cks_ff;
      xor_in       = xor_ff;
      hex_acc_in   = hex_acc_ff;
      hex_seen_in  = hex_seen_ff;
      hex_bad_in   = hex_bad_ff;
      field_num_in = field_num_ff;
      too_many_in  = too_many_ff;
      id_cnt_in    = id_cnt_ff;
      id_bad_in    = id_bad_ff;
      acc_in       = acc_ff;
      seen_in      = seen_ff;
      num_bad_in   = num_bad_ff;
      values_in    = values_ff;
      close        = 1'b0;
      id_ok_char   = 1'b0;
      for (int i = 0; i < ID_LEN; i++) begin
         if (id_cnt_ff == 2'(i) && item.id_hit[i]) begin
            id_ok_char = 1'b1;
         end
      end
      // Next decimal value: acc*10 + digit, with overflow in the top bits
      wide = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {32'd0, item.digit};

      if (cks_ff) begin
         // Checksum text after the first star
         hex_seen_in = 1'b1;
         if (!hex_bad_ff) begin
            if (!item.is_hex || hex_acc_ff[7:4] != 4'd0) begin
               hex_bad_in = 1'b1;
            end else begin
               hex_acc_in = {hex_acc_ff[3:0], item.hex};
            end
         end
      end else if (item.is_star) begin
         close  = 1'b1;
         cks_in = 1'b1;
      end else begin
         xor_in = xor_ff ^ item.data;
         if (!too_many_ff) begin
            if (item.is_comma) begin
               if (field_num_ff >= LAST_FIELD) begin
                  too_many_in = 1'b1;
               end else begin
                  close        = 1'b1;
                  field_num_in = field_num_ff + 1'b1;
               end
            end else if (field_num_ff == 3'd0) begin
               if (!id_bad_ff) begin
                  if (id_ok_char) begin
                     id_cnt_in = id_cnt_ff + 1'b1;
                  end else begin
                     id_bad_in = 1'b1;
                  end
               end
            end else begin
               seen_in = 1'b1;
               if (!num_bad_ff) begin
                  if (!item.is_digit || wide[35:32] != 4'd0) begin
                     num_bad_in = 1'b1;
                  end else begin
                     acc_in = wide[31:0];
                  end
               end
            end
         end
      end

      // Close the current field
      if (close && !too_many_ff) begin
         if (field_num_ff == 3'd0) begin
            if (id_cnt_ff != ID_DONE) begin
               id_bad_in = 1'b1;
            end
         end else begin
            if (!seen_ff) begin
               num_bad_in = 1'b1;
            end
            for (int k = 0; k < NUM_READINGS; k++) begin
               if (field_num_ff == 3'(k + 1)) begin
                  values_in[k] = acc_ff;
               end
            end
         end
         acc_in  = '0;
         seen_in = 1'b0;
      end

      // Final status in priority order
      if (!cks_in) begin
         st = ST_NO_STAR;
      end else if (!hex_seen_in || hex_bad_in) begin
         st = ST_BAD_HEX;
      end else if (hex_acc_in != xor_in) begin
         st = ST_MISMATCH;
      end else if (too_many_in) begin
         st = ST_TOO_MANY;
      end else if (field_num_in != LAST_FIELD) begin
         st = ST_FIELD_COUNT;
      end else if (id_bad_in) begin
         st = ST_BAD_ID;
      end else if (num_bad_in) begin
         st = ST_BAD_NUMBER;
      end else begin
         st = ST_OK;
      end
      rsp_data        = '0;
      rsp_data.status = st;
      if (st == ST_OK) begin
         rsp_data.reading_1 = values_in[0];
         rsp_data.reading_2 = values_in[1];
         rsp_data.reading_3 = values_in[2];
         rsp_data.reading_4 = values_in[3];
         rsp_data.reading_5 = values_in[4];
         rsp_data.reading_6 = values_in[5];
      end

      // Drop all packet state but the held readings after the closing byte
      if (item.last) begin
         cks_in       = 1'b0;
         xor_in       = '0;
         hex_acc_in   = '0;
         hex_seen_in  = 1'b0;
         hex_bad_in   = 1'b0;
         field_num_in = '0;
         too_many_in  = 1'b0;
         id_cnt_in    = '0;
         id_bad_in    = 1'b0;
         acc_in       = '0;
         seen_in      = 1'b0;
         num_bad_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cks_ff       <= 1'b0;
         xor_ff       <= '0;
         hex_acc_ff   <= '0;
         hex_seen_ff  <= 1'b0;
         hex_bad_ff   <= 1'b0;
         field_num_ff <= '0;
         too_many_ff  <= 1'b0;
         id_cnt_ff    <= '0;
         id_bad_ff    <= 1'b0;
         acc_ff       <= '0;
         seen_ff      <= 1'b0;
         num_bad_ff   <= 1'b0;
      end else if (fire) begin
         cks_ff       <= cks_in;
         xor_ff       <= xor_in;
         hex_acc_ff   <= hex_acc_in;
         hex_seen_ff  <= hex_seen_in;
         hex_bad_ff   <= hex_bad_in;
         field_num_ff <= field_num_in;
         too_many_ff  <= too_many_in;
         id_cnt_ff    <= id_cnt_in;
         id_bad_ff    <= id_bad_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         num_bad_ff   <= num_bad_in;
      end
   end

   // Hold captured readings; every field is written before an ok result reads it
   always_ff @(posedge clock) begin
      if (fire) begin
         values_ff <= values_in;
      end
   end

endmodule

// ===== rtl/tsp_checker.sv =====
// Port-level checks for the telemetry sentence parser and the bind that
// attaches them to the top level. Depends on tsp_pkg.
module tsp_checker import tsp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    push,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   // Both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // The request queue only fills after an offered request
   a_full_after_push: assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push))
      else $error("full rose without a request");

   // An error result carries zero readings
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status != ST_OK) |->
      (rsp_data.reading_1 == '0 && rsp_data.reading_2 == '0 &&
       rsp_data.reading_3 == '0 && rsp_data.reading_4 == '0 &&
       rsp_data.reading_5 == '0 && rsp_data.reading_6 == '0))
      else $error("nonzero reading on error status");

   // A waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed");

endmodule

bind telemetry_sentence_parser tsp_checker u_tsp_checker (
   .clock    (clock),
   .reset    (reset),
   .push     (push),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

// ===== dv/tb_telemetry_sentence_parser.sv =====
// Self-checking testbench for telemetry_sentence_parser: drives byte requests,
// predicts the status and readings of each closed sentence and checks every response.
// Depends on tsp_pkg and the telemetry_sentence_parser RTL.
module tb_telemetry_sentence_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import tsp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 1500;

   typedef struct {
      req_type req;
      bit      drain;
   } stim_type;

   // DUT connections; the driven inputs are known from time zero
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   // Stimulus and scoreboard
   stim_type   pending_bytes [$];
   rsp_type    expected_reports [$];
   logic [7:0] sentence [$];
   int sentences_built = 0;
   int closings_sent = 0;
   int reports_checked = 0;
   int failures = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int send_calm = 0;
   int recv_gap = 0;
   int recv_calm = 0;
   int long_hold = 0;
   bit hold_done = 1'b0;

   // Shadow parser state
   logic        in_hex;
   logic [7:0]  sum_xor;
   logic [7:0]  hex_val;
   logic        hex_any;
   logic        hex_err;
   logic [2:0]  field_idx;
   logic        extra_field;
   logic [1:0]  id_hits;
   logic        id_err;
   logic [31:0] num_val;
   logic        num_any;
   logic        num_err;
   logic [31:0] readings [NUM_READINGS];

   telemetry_sentence_parser u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   task automatic clear_parser();
      in_hex = 1'b0;
      sum_xor = '0;
      hex_val = '0;
      hex_any = 1'b0;
      hex_err = 1'b0;
      field_idx = '0;
      extra_field = 1'b0;
      id_hits = '0;
      id_err = 1'b0;
      num_val = '0;
      num_any = 1'b0;
      num_err = 1'b0;
      foreach (readings[k]) readings[k] = '0;
   endtask

   // Close the field being collected; fields past the seventh are ignored
   task automatic finish_field();
      if (!extra_field) begin
         if (field_idx == 3'd0) begin
            if (id_hits != ID_DONE) id_err = 1'b1;
         end else if (field_idx <= LAST_FIELD) begin
            if (!num_any) num_err = 1'b1;
            readings[field_idx - 3'd1] = num_val;
         end
         num_val = '0;
         num_any = 1'b0;
      end
   endtask

   // Advance the shadow parser by one accepted byte; queue a report on the last one
   task automatic parse_byte(input req_type r);
      logic [7:0]  c;
      logic [3:0]  nib;
      logic        nib_ok;
      logic [63:0] wide;
      rsp_type     rep;
      c = r.byte_in;
      if (in_hex) begin
         // checksum text: every byte after the first star, further stars included
         hex_any = 1'b1;
         nib_ok = 1'b1;
         nib = '0;
         if (c >= CH_ZERO && c <= CH_NINE) nib = 4'(c - CH_ZERO);
         else if (c >= CH_UPA && c <= CH_UPF) nib = 4'(c - CH_UPA + 8'd10);
         else if (c >= CH_LOA && c <= CH_LOF) nib = 4'(c - CH_LOA + 8'd10);
         else nib_ok = 1'b0;
         if (!hex_err) begin
            if (!nib_ok) hex_err = 1'b1;
            else if ({hex_val, 4'h0} + nib > 12'd255) hex_err = 1'b1;
            else hex_val = {hex_val[3:0], nib};
         end
      end else if (c == CH_STAR) begin
         finish_field();
         in_hex = 1'b1;
      end else begin
         sum_xor = sum_xor ^ c;
         if (!extra_field) begin
            if (c == CH_COMMA) begin
               if (field_idx >= LAST_FIELD) extra_field = 1'b1;
               else begin
                  finish_field();
                  field_idx = field_idx + 3'd1;
               end
            end else if (field_idx == 3'd0) begin
               if (!id_err) begin
                  if (id_hits < ID_DONE && c == ID_TEXT[id_hits]) id_hits = id_hits + 2'd1;
                  else id_err = 1'b1;
               end
            end else begin
               num_any = 1'b1;
               if (!num_err) begin
                  if (c < CH_ZERO || c > CH_NINE) num_err = 1'b1;
                  else begin
                     wide = 64'(num_val) * 64'd10 + 64'(c - CH_ZERO);
                     if (wide > 64'hFFFF_FFFF) num_err = 1'b1;
                     else num_val = wide[31:0];
                  end
               end
            end
         end
      end

      if (r.end_of_packet) begin
         // lowest nonzero code wins; readings only on a clean sentence
         rep = '0;
         if (!in_hex) rep.status = ST_NO_STAR;
         else if (!hex_any || hex_err) rep.status = ST_BAD_HEX;
         else if (hex_val != sum_xor) rep.status = ST_MISMATCH;
         else if (extra_field) rep.status = ST_TOO_MANY;
         else if (field_idx != LAST_FIELD) rep.status = ST_FIELD_COUNT;
         else if (id_err) rep.status = ST_BAD_ID;
         else if (num_err) rep.status = ST_BAD_NUMBER;
         else begin
            rep.status = ST_OK;
            rep.reading_1 = readings[0];
            rep.reading_2 = readings[1];
            rep.reading_3 = readings[2];
            rep.reading_4 = readings[3];
            rep.reading_5 = readings[4];
            rep.reading_6 = readings[5];
         end
         expected_reports = {expected_reports, rep};
         clear_parser();
      end
   endtask

   // Compare one response with the oldest predicted report
   task automatic check_report(input rsp_type got);
      rsp_type     want;
      logic [31:0] want_r [NUM_READINGS];
      logic [31:0] got_r [NUM_READINGS];
      if (expected_reports.size() == 0) begin
         $display("%0t ns: response with none expected, status %0d", $time, got.status);
         failures++;
      end else begin
         want = expected_reports.pop_front();
         want_r = '{want.reading_1, want.reading_2, want.reading_3,
                    want.reading_4, want.reading_5, want.reading_6};
         got_r = '{got.reading_1, got.reading_2, got.reading_3,
                   got.reading_4, got.reading_5, got.reading_6};
         if (got.status !== want.status) begin
            $display("%0t ns: status expected %0d actual %0d", $time, want.status, got.status);
            failures++;
         end
         for (int k = 0; k < NUM_READINGS; k++) begin
            if (got_r[k] !== want_r[k]) begin
               $display("%0t ns: reading_%0d expected %0d actual %0d",
                        $time, k + 1, want_r[k], got_r[k]);
               failures++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(16, 64);
      return $urandom_range(0, 13);
   endfunction

   // Append one character to the sentence being built
   task automatic add_char(input logic [7:0] ch);
      sentence = {sentence, ch};
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   task automatic put_hex(input logic [11:0] v, input int ndig, input bit upper);
      logic [3:0] nib;
      for (int i = ndig - 1; i >= 0; i--) begin
         nib = v[4*i +: 4];
         if (nib < 4'd10) add_char(CH_ZERO + 8'(nib));
         else add_char((upper ? CH_UPA : CH_LOA) + 8'(nib) - 8'd10);
      end
   endtask

   function automatic logic [7:0] payload_parity();
      logic [7:0] p;
      p = '0;
      foreach (sentence[i]) p = p ^ sentence[i];
      return p;
   endfunction

   // Append one decimal field, well formed or broken on purpose
   task automatic put_number(input bit broken);
      if (broken) begin
         case ($urandom_range(0, 5))
            0: ;
            1: put_text("12a4");
            2: put_text("4294967296");
            3: put_text("18446744073709551616");
            4: put_text("-7");
            default: put_text("99999999990");
         endcase
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: put_text($sformatf("%0d", $urandom_range(0, 999)));
            5, 6: put_text($sformatf("%0d", $urandom()));
            7: put_text("4294967295");
            8: put_text("0");
            default: put_text($sformatf("00%0d", $urandom_range(0, 99)));
         endcase
      end
   endtask

   // Build one random sentence: mostly well formed, some broken on purpose, some noise
   task automatic build_sentence();
      int         kind;
      int         nf;
      int         bad_at;
      logic [7:0] parity;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 10)) add_char(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 1) add_char(CH_STAR);
         return;
      end
      // identifier field, sometimes wrong
      if (kind < 14 || (kind >= 40 && kind < 44)) begin
         case ($urandom_range(0, 6))
            0: put_text("MB2");
            1: put_text("MB");
            2: put_text("MB11");
            3: put_text("mb1");
            4: ;
            5: put_text("XB1");
            default: put_text("MB1X");
         endcase
      end else begin
         put_text("MB1");
      end
      nf = 6;
      if (kind >= 14 && kind < 19) nf = $urandom_range(0, 5);
      else if (kind >= 19 && kind < 24) nf = $urandom_range(7, 9);
      bad_at = 0;
      if ((kind >= 24 && kind < 32) || (kind >= 40 && kind < 44)) bad_at = $urandom_range(1, nf);
      for (int k = 1; k <= nf; k++) begin
         add_char(CH_COMMA);
         put_number(k == bad_at);
      end
      parity = payload_parity();
      // drop the star entirely
      if (kind >= 44 && kind < 50) return;
      add_char(CH_STAR);
      if (kind >= 50 && kind < 58) begin
         case ($urandom_range(0, 4))
            0: ;
            1: begin
               put_hex(12'(parity), 2, 1'b1);
               add_char(CH_STAR);
            end
            2: begin
               add_char(CH_STAR);
               put_hex(12'(parity), 2, 1'b0);
            end
            3: put_hex(12'h100 + 12'($urandom_range(0, 255)), 3, 1'($urandom_range(0, 1)));
            default: begin
               put_hex(12'(parity >> 4), 1, 1'b1);
               add_char(8'h47);
            end
         endcase
      end else if (kind >= 58 && kind < 64) begin
         put_hex(12'(parity ^ 8'($urandom_range(1, 255))), 2, 1'($urandom_range(0, 1)));
      end else begin
         put_hex(12'(parity), (parity < 8'd16) ? $urandom_range(1, 3) : $urandom_range(2, 3),
                 1'($urandom_range(0, 1)));
      end
   endtask

   // Move the sentence being built into the request queue, last byte flagged
   task automatic queue_sentence(input bit drain);
      stim_type it;
      if (sentence.size() == 0) add_char(CH_COMMA);
      foreach (sentence[i]) begin
         it.req.byte_in = sentence[i];
         it.req.end_of_packet = (i == sentence.size() - 1);
         it.drain = drain && (i == 0);
         pending_bytes = {pending_bytes, it};
      end
      sentence.delete();
      sentences_built++;
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_bytes
      logic     next_push;
      req_type  next_req;
      stim_type head;
      if (reset) begin
         push <= 1'b0;
      end else begin
         next_push = push;
         next_req = req_data;
         if (push && !full) begin
            if (req_data.end_of_packet) closings_sent++;
            next_push = 1'b0;
         end
         // offer the next byte after its gap; a drain mark waits for every report
         if (!next_push && pending_bytes.size() != 0) begin
            if (send_gap > 0) send_gap--;
            else if (!pending_bytes[0].drain || reports_checked == closings_sent) begin
               head = pending_bytes.pop_front();
               next_req = head.req;
               next_push = 1'b1;
               send_gap = draw_wait(send_calm);
            end
         end
         push <= next_push;
         req_data <= next_req;
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : watch_reports
      logic next_pop;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         next_pop = pop;
         if (pop && !empty) begin
            check_report(rsp_data);
            reports_checked++;
            next_pop = 1'b0;
            recv_gap = draw_wait(recv_calm);
         end
         if (push && !full) parse_byte(req_data);
         if (!next_pop && long_hold == 0) begin
            if (recv_gap > 0) recv_gap--;
            else next_pop = 1'b1;
         end
         pop <= next_pop;
      end
   end

   // Hold the receiver off once for a long stretch so the block backs up
   always @(posedge clock) begin : hold_receiver
      if (reset) begin
         long_hold <= 0;
      end else if (!hold_done && reports_checked >= 12) begin
         long_hold <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (long_hold > 0) begin
         long_hold <= long_hold - 1;
      end
   end

   // Stop a hung run
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_parser();

      // Directed: single-byte packets, empty and extra-star checksums, hex overflow
      put_text("*");
      queue_sentence(1'b0);
      add_char(8'hFF);
      queue_sentence(1'b0);
      add_char(8'h00);
      queue_sentence(1'b0);
      put_text("*00");
      queue_sentence(1'b0);
      put_text("**");
      queue_sentence(1'b0);
      put_text("*1ff");
      queue_sentence(1'b0);
      put_text("MB1*");
      put_hex(12'(payload_parity() ^ CH_STAR), 2, 1'b1);
      queue_sentence(1'b0);

      // Random sentences; one pauses the sender until all reports are in
      while (pending_bytes.size() < 1570 || sentences_built < 56) begin
         build_sentence();
         queue_sentence(sentences_built == 25);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || push) @(posedge clock);
      while (reports_checked != closings_sent) @(posedge clock);
      repeat (10) @(posedge clock);

      if (failures == 0 && expected_reports.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tsp_pkg.sv
rtl/tsp_fifo.sv
rtl/tsp_front.sv
rtl/tsp_back.sv
rtl/telemetry_sentence_parser.sv
rtl/tsp_checker.sv
dv/tb_telemetry_sentence_parser.sv
